[sv/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, command codes and slot tables for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam logic [2:0] MODE_START   = 3'd0;
  localparam logic [2:0] MODE_STOP    = 3'd1;
  localparam logic [2:0] MODE_WRITE   = 3'd2;
  localparam logic [2:0] MODE_READ    = 3'd3;
  localparam logic [2:0] MODE_SEND_ACK = 3'd4;
  localparam logic [2:0] MODE_RX_ACK  = 3'd5;

  localparam logic [15:0] SLOT_TICKS_RESET = 16'd10;

  typedef struct packed {
    logic       cmd;
    logic [2:0] mode;
    logic [7:0] load;
    logic       sda;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack_in;
  } res_t;

  function automatic logic [4:0] slot_count(input logic [2:0] mode);
    logic [4:0] n;
    case (mode)
      MODE_START:    n = 5'd4;
      MODE_STOP:     n = 5'd3;
      MODE_WRITE:    n = 5'd24;
      MODE_READ:     n = 5'd25;
      MODE_SEND_ACK: n = 5'd3;
      MODE_RX_ACK:   n = 5'd4;
      default:       n = 5'd1;
    endcase
    return n;
  endfunction

endpackage

[sv/i2cm_front.sv]
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts tick transactions, decodes the command and registers the result.
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic           cmd_valid_i,
  input  logic [2:0]     mode_i,
  input  logic [7:0]     tx_byte_i,
  input  logic           ack_out_i,
  input  logic           sda_in_i,
  output logic           valid_o,
  input  logic           ready_i,
  output i2cm_pkg::item_t item_o
);

  logic            valid_q;
  logic            valid_d;
  i2cm_pkg::item_t item_q;
  i2cm_pkg::item_t item_d;
  logic            take;

  assign ready_o = !valid_q || ready_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    item_d.cmd  = cmd_valid_i && (mode_i <= i2cm_pkg::MODE_RX_ACK);
    item_d.mode = mode_i;
    item_d.sda  = sda_in_i;
    case (mode_i)
      i2cm_pkg::MODE_WRITE:    item_d.load = tx_byte_i;
      i2cm_pkg::MODE_SEND_ACK: item_d.load = {7'd0, ack_out_i};
      default:                 item_d.load = 8'd0;
    endcase
    valid_d = take || (valid_q && !ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[sv/i2cm_queue.sv]
// ----------------------------------------------------------------------------
// i2cm_queue
// Small FIFO of decoded ticks between the front end and the sequencer.
// ----------------------------------------------------------------------------
module i2cm_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            ready_o,
  input  i2cm_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            pop_i,
  output i2cm_pkg::item_t item_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  i2cm_pkg::item_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign ready_o = (count_q != CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= item_i;
    end
  end

endmodule

[sv/i2cm_back.sv]
// ----------------------------------------------------------------------------
// i2cm_back
// Slot sequencer: runs one tick per queued transaction and registers the result.
// ----------------------------------------------------------------------------
module i2cm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     slot_ticks_i,
  input  logic            valid_i,
  output logic            pop_o,
  input  i2cm_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            ready_i,
  output i2cm_pkg::res_t  res_o
);

  logic           running_q, running_d;
  logic [15:0]    timer_q, timer_d;
  logic [4:0]     idx_q, idx_d;
  logic [2:0]     mode_q, mode_d;
  logic [7:0]     shift_q, shift_d;
  logic           scl_q, scl_d;
  logic           sda_q, sda_d;
  logic           ack_q, ack_d;
  logic [1:0]     phase_q, phase_d;
  logic [2:0]     bit_q, bit_d;
  logic           out_valid_q;
  i2cm_pkg::res_t res_q, res_d;

  logic           consume;
  logic           start;
  logic [2:0]     mode_c;
  logic [4:0]     idx_c;
  logic [15:0]    timer_c;
  logic [1:0]     phase_c;
  logic [2:0]     bit_c;
  logic [16:0]    hold;
  logic [16:0]    t_next;
  logic           last;

  assign consume = valid_i && (!out_valid_q || ready_i);
  assign pop_o   = consume;

  always_comb begin
    start   = !running_q && item_i.cmd;
    mode_c  = start ? item_i.mode : mode_q;
    idx_c   = start ? 5'd0 : idx_q;
    timer_c = start ? 16'd0 : timer_q;
    phase_c = start ? 2'd0 : phase_q;
    bit_c   = start ? 3'd0 : bit_q;
    hold    = {1'b0, (slot_ticks_i == 16'd0) ? 16'd1 : slot_ticks_i};
    t_next  = {1'b0, timer_c} + 17'd1;
    last    = ({1'b0, idx_c} + 6'd1) >= {1'b0, i2cm_pkg::slot_count(mode_c)};

    running_d = running_q || start;
    timer_d   = timer_c;
    idx_d     = idx_c;
    mode_d    = mode_c;
    shift_d   = start ? item_i.load : shift_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    ack_d     = ack_q;
    phase_d   = phase_c;
    bit_d     = bit_c;
    res_d     = '0;

    if (running_d) begin
      if (timer_c == 16'd0) begin
        case (mode_c)
          i2cm_pkg::MODE_START: begin
            case (idx_c)
              5'd0:    sda_d = 1'b1;
              5'd1:    scl_d = 1'b1;
              5'd2:    sda_d = 1'b0;
              default: scl_d = 1'b0;
            endcase
          end
          i2cm_pkg::MODE_STOP: begin
            case (idx_c)
              5'd0:    sda_d = 1'b0;
              5'd1:    scl_d = 1'b1;
              default: sda_d = 1'b1;
            endcase
          end
          i2cm_pkg::MODE_WRITE: begin
            case (phase_c)
              2'd0:    sda_d = shift_d[3'd7 - bit_c];
              2'd1:    scl_d = 1'b1;
              default: scl_d = 1'b0;
            endcase
          end
          i2cm_pkg::MODE_READ: begin
            if (idx_c == 5'd0) begin
              sda_d = 1'b1;
            end else begin
              case (phase_c)
                2'd0:    scl_d = 1'b1;
                2'd1:    shift_d = {shift_d[6:0], item_i.sda};
                default: scl_d = 1'b0;
              endcase
            end
          end
          i2cm_pkg::MODE_SEND_ACK: begin
            case (idx_c)
              5'd0:    sda_d = shift_d[0];
              5'd1:    scl_d = 1'b1;
              default: scl_d = 1'b0;
            endcase
          end
          i2cm_pkg::MODE_RX_ACK: begin
            case (idx_c)
              5'd0:    sda_d = 1'b1;
              5'd1:    scl_d = 1'b1;
              5'd2:    ack_d = item_i.sda;
              default: scl_d = 1'b0;
            endcase
          end
          default: begin
          end
        endcase
      end

      res_d.busy = 1'b1;
      timer_d    = t_next[15:0];
      if (t_next >= hold) begin
        timer_d = 16'd0;
        if (last) begin
          res_d.done = 1'b1;
          running_d  = 1'b0;
          idx_d      = 5'd0;
          if (mode_c == i2cm_pkg::MODE_READ) begin
            res_d.rx_byte = shift_d;
          end
          if (mode_c == i2cm_pkg::MODE_RX_ACK) begin
            res_d.ack_in = ack_d;
          end
        end else begin
          idx_d = idx_c + 5'd1;
          if (mode_c == i2cm_pkg::MODE_READ && idx_c == 5'd0) begin
            phase_d = 2'd0;
            bit_d   = 3'd0;
          end else if (phase_c == 2'd2) begin
            phase_d = 2'd0;
            bit_d   = bit_c + 3'd1;
          end else begin
            phase_d = phase_c + 2'd1;
          end
        end
      end
    end

    res_d.scl = scl_d;
    res_d.sda = sda_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      timer_q     <= 16'd0;
      idx_q       <= 5'd0;
      mode_q      <= i2cm_pkg::MODE_START;
      shift_q     <= 8'd0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      ack_q       <= 1'b0;
      phase_q     <= 2'd0;
      bit_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (consume) begin
        running_q <= running_d;
        timer_q   <= timer_d;
        idx_q     <= idx_d;
        mode_q    <= mode_d;
        shift_q   <= shift_d;
        scl_q     <= scl_d;
        sda_q     <= sda_d;
        ack_q     <= ack_d;
        phase_q   <= phase_d;
        bit_q     <= bit_d;
      end
      if (consume) begin
        out_valid_q <= 1'b1;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      res_q <= res_d;
    end
  end

  assign valid_o = out_valid_q;
  assign res_o   = res_q;

endmodule

[sv/i2c_master_bit_engine.sv]
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Bit-level I2C master sequencer driven by one tick transaction per time step.
// ----------------------------------------------------------------------------
// Each slave-side transaction is one time tick carrying the sampled SDA level
// and an optional command in tuser (start, stop, write, read, send ack,
// receive ack). Each master-side transaction is the matching result: pin
// levels, busy, the received byte and ack, with tlast marking the final tick
// of a command. Every tick gives exactly one result, in order.
// The slot length in ticks is set through cfg_we_i/cfg_wdata_i; write it only
// when no tick is in flight.
// Throughput is one tick per clock cycle while the receiver keeps up. From the
// slave-side handshake, a tick passes the decode register, the tick queue and
// the sequencer's output register before its result appears.
// Reset releases both pins, loads a slot length of 10 ticks and empties the
// pipeline. When the receiver stalls, the output register holds its result,
// the queue fills, and then s_axis_tready drops until space frees up.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tx_byte[7:0], ack_out[8], sda_in[9], zero[15:10]
  input  logic [15:0] s_axis_tdata,
  // cmd_valid[0], mode[3:1]
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_out[0], sda_out[1], busy_res[2], rx_byte[10:3], ack_in[11], zero[15:12]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic [15:0]     slot_ticks_q;
  logic            f_valid;
  logic            f_ready;
  i2cm_pkg::item_t f_item;
  logic            q_valid;
  logic            q_pop;
  i2cm_pkg::item_t q_item;
  i2cm_pkg::res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_ticks_q <= i2cm_pkg::SLOT_TICKS_RESET;
    end else if (cfg_we_i) begin
      slot_ticks_q <= cfg_wdata_i;
    end
  end

  i2cm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .cmd_valid_i (s_axis_tuser[0]),
    .mode_i      (s_axis_tuser[3:1]),
    .tx_byte_i   (s_axis_tdata[7:0]),
    .ack_out_i   (s_axis_tdata[8]),
    .sda_in_i    (s_axis_tdata[9]),
    .valid_o     (f_valid),
    .ready_i     (f_ready),
    .item_o      (f_item)
  );

  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .ready_o (f_ready),
    .item_i  (f_item),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (q_item)
  );

  i2cm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slot_ticks_i (slot_ticks_q),
    .valid_i      (q_valid),
    .pop_o        (q_pop),
    .item_i       (q_item),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {4'd0, res.ack_in, res.rx_byte, res.busy, res.sda, res.scl};
  assign m_axis_tlast = res.done;

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[2])
    else $error("command end reported without busy");

  a_rx_on_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[10:3] != 8'd0)) |-> m_axis_tlast)
    else $error("received byte shown outside a command end");

  a_ack_on_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[11]) |-> m_axis_tlast)
    else $error("received ack shown outside a command end");

endmodule
